/* rtl/core/fala_pkg.sv */
// ----------------------------------------------------------------------------
// fala_pkg
// Types and constants shared by the flash access lock arbiter modules.
// ----------------------------------------------------------------------------
package fala_pkg;

	typedef enum logic [2:0] {
		REQ_CTRL_RD  = 3'd0,
		REQ_CTRL_WR  = 3'd1,
		REQ_STAT_RD  = 3'd2,
		REQ_STAT_WR  = 3'd3,
		REQ_INTERNAL = 3'd4,
		REQ_TICK     = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		RES_OK   = 2'd0,
		RES_ERR  = 2'd1,
		RES_WAIT = 2'd2
	} res_code_t;

	localparam logic [1:0] MODE_UNLOCKED = 2'd0;
	localparam logic [1:0] MODE_RESERVED = 2'd1;
	localparam logic [1:0] MODE_LOCKED   = 2'd2;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_ONE  = 8'h31;

	localparam logic [31:0] RELOAD_DEFAULT = 32'd60000;

	localparam int unsigned IN_DATA_W  = 16;
	localparam int unsigned IN_USER_W  = 3;
	localparam int unsigned OUT_DATA_W = 8;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] write_char;
		logic       want_access;
	} item_t;

	typedef struct packed {
		logic       wake_waiters;
		logic       lock_held;
		logic [1:0] read_value;
		logic [1:0] result_code;
	} result_t;

endpackage

/* rtl/core/fala_lock_unit.sv */
// ----------------------------------------------------------------------------
// fala_lock_unit
// Lock state registers, timeout register and the per-item update logic.
// ----------------------------------------------------------------------------
module fala_lock_unit #(
	parameter int unsigned NEST_BITS  = 8,
	parameter int unsigned TIMER_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	input  logic             step,
	input  fala_pkg::item_t  item,
	output fala_pkg::result_t result
);
	import fala_pkg::*;

	localparam logic [NEST_BITS-1:0] NEST_MAX = {NEST_BITS{1'b1}};

	logic [31:0]           reload_q;
	logic [1:0]            mode_q, mode_d;
	logic                  lock_q, lock_d;
	logic [NEST_BITS-1:0]  nest_q, nest_d;
	logic [TIMER_BITS-1:0] ticks_q, ticks_d;
	logic [TIMER_BITS-1:0] reload_val;
	logic                  promote;

	assign reload_val = reload_q[TIMER_BITS-1:0];
	assign promote    = (mode_q == MODE_RESERVED) && !lock_q;

	always_comb begin
		mode_d  = mode_q;
		lock_d  = lock_q;
		nest_d  = nest_q;
		ticks_d = ticks_q;
		result  = '0;
		result.result_code = RES_OK;
		unique case (item.req_type)
			REQ_CTRL_RD: begin
				if (promote) begin
					mode_d = MODE_LOCKED;
					lock_d = 1'b1;
				end
				result.read_value = mode_d;
			end
			REQ_CTRL_WR: begin
				ticks_d = reload_val;
				if (item.write_char == ASCII_ONE) begin
					if (mode_q == MODE_UNLOCKED) begin
						if (!lock_q) begin
							mode_d = MODE_LOCKED;
							lock_d = 1'b1;
						end
						result.wake_waiters = 1'b1;
					end else if (mode_q == MODE_RESERVED) begin
						result.result_code = RES_ERR;
					end else begin
						result.wake_waiters = 1'b1;
					end
				end else if (item.write_char == ASCII_ZERO) begin
					if (mode_q == MODE_RESERVED) begin
						mode_d = MODE_UNLOCKED;
					end else if (mode_q != MODE_UNLOCKED) begin
						mode_d = MODE_UNLOCKED;
						lock_d = 1'b0;
					end
					result.wake_waiters = 1'b1;
				end else begin
					result.result_code = RES_ERR;
				end
			end
			REQ_STAT_RD: begin
				if (promote) begin
					mode_d = MODE_LOCKED;
					lock_d = 1'b1;
				end
				result.read_value = {1'b0, lock_d};
			end
			REQ_STAT_WR: begin
				result.result_code = RES_ERR;
			end
			REQ_INTERNAL: begin
				if (nest_q == '0) begin
					if (item.want_access) begin
						if (!lock_q) begin
							lock_d  = 1'b1;
							nest_d  = {{(NEST_BITS-1){1'b0}}, 1'b1};
							ticks_d = reload_val;
						end else begin
							result.result_code = RES_WAIT;
						end
					end else begin
						ticks_d = reload_val;
					end
				end else if (!item.want_access) begin
					nest_d  = nest_q - 1'b1;
					if (nest_d == '0) begin
						lock_d = 1'b0;
					end
					ticks_d = reload_val;
				end else if (nest_q == NEST_MAX) begin
					result.result_code = RES_ERR;
				end else begin
					nest_d  = nest_q + 1'b1;
					ticks_d = reload_val;
				end
			end
			REQ_TICK: begin
				if (mode_q == MODE_UNLOCKED) begin
					ticks_d = reload_val;
				end else if (nest_q == '0) begin
					if (ticks_q == '0) begin
						mode_d  = MODE_UNLOCKED;
						lock_d  = 1'b0;
						ticks_d = reload_val;
					end else begin
						ticks_d = ticks_q - 1'b1;
					end
				end
				result.wake_waiters = 1'b1;
			end
			default: begin
				result.result_code = RES_ERR;
			end
		endcase
		result.lock_held = lock_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= RELOAD_DEFAULT;
		end else if (cfg_we) begin
			reload_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_UNLOCKED;
			lock_q  <= 1'b0;
			nest_q  <= '0;
			ticks_q <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			lock_q  <= lock_d;
			nest_q  <= nest_d;
			ticks_q <= ticks_d;
		end
	end

endmodule

/* rtl/core/flash_access_lock_arbiter.sv */
// ----------------------------------------------------------------------------
// flash_access_lock_arbiter
// Arbitrates one flash lock between an external owner and nested internal
// users, with a tick-driven timeout that forces an external lock free.
// ----------------------------------------------------------------------------
// A result is offered from the result register once its item has moved on
// from the input register; a stall on m_axis_tready holds both registers.
// Throughput: one item per cycle while the output is not stalled; the lock
// state updates as the item moves from the input into the result register.
// Reset: mode unlocked, lock free, nesting count and countdown zero, and the
// timeout reload register returns to 60000.
module flash_access_lock_arbiter #(
	parameter int unsigned NEST_BITS  = 8,
	parameter int unsigned TIMER_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [31:0]                          cfg_wdata,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// Fields from bit 0: write_char[7:0], want_access[8], zero padding.
	input  logic [fala_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// Fields from bit 0: req_type[2:0].
	input  logic [fala_pkg::IN_USER_W-1:0]       s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// Fields from bit 0: result_code[1:0], read_value[3:2], lock_held[4],
	// wake_waiters[5], zero padding.
	output logic [fala_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
	import fala_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t result;
	logic    out_load;
	logic    step;

	assign out_load      = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_load;
	assign s_axis_tready = !valid_s1 || out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.req_type    <= s_axis_tuser[2:0];
			item_s1.write_char  <= s_axis_tdata[7:0];
			item_s1.want_access <= s_axis_tdata[8];
		end
	end

	fala_lock_unit #(
		.NEST_BITS  (NEST_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_lock (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (step),
		.item      (item_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q};

endmodule
